[rtl/kvi_pkg.sv]
// Package for the keyframe vector interpolator: sizes, widths and result codes.
// No dependencies.
`default_nettype none
package kvi_pkg;
	localparam int MaxKeysDefault = 64;
	localparam int TimeW = 32;
	localparam int ValW = 32;
	localparam int AlphaBits = 24;
	localparam int CountW = 7;
	localparam int SlotW = 6;

	typedef enum logic [1:0] {
		CLAMP_NONE  = 2'd0,
		CLAMP_FIRST = 2'd1,
		CLAMP_LAST  = 2'd2
	} clamp_t;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_EVAL = 1'b1;
	localparam logic [0:0] REG_KEY_COUNT = 1'b0;
endpackage
`default_nettype wire

[rtl/keyframe_vector_interpolator_top.sv]
// Keyframe vector interpolator, top level with APB register port.
// A load writes its key into the table. An evaluate reads slot 0, runs the binary
// search (6 steps with 64 keys in use, each reading the mid key), reads the two
// bracketing keys, runs the serial divider that makes alpha, and does the three
// multiply-add passes. Clamped results skip the divide: a query before slot 0 leaves
// after the first read, one at or past the last key after the left key read.
// in_ready stays low until the result transfers, so one evaluate is in flight at a time.
// The shared table read port and the bit-serial divider set the rate. Depends on kvi_pkg.
`default_nettype none
module keyframe_vector_interpolator_top #(
	parameter int MAX_KEYS = kvi_pkg::MaxKeysDefault
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [0:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        op,
	input  wire logic [5:0]  key_slot,
	input  wire logic [31:0] key_time,
	input  wire logic signed [31:0] value_x,
	input  wire logic signed [31:0] value_y,
	input  wire logic signed [31:0] value_z,
	input  wire logic [31:0] query_time,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic [5:0]       left_slot,
	output logic [1:0]       clamp_kind
);
	localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
	localparam int NW = AW + 1;
	localparam int AB = kvi_pkg::AlphaBits;

	typedef enum logic [3:0] {
		S_IDLE, S_FIRST, S_SRCH_A, S_SRCH_R, S_LEFT, S_RIGHT, S_DIV,
		S_RDX, S_MUL, S_ADD, S_OUT
	} state_t;

	// table memories: one write address and one shared read address, read data registered
	logic [31:0] time_mem [MAX_KEYS];
	logic [31:0] x_mem [MAX_KEYS];
	logic [31:0] y_mem [MAX_KEYS];
	logic [31:0] z_mem [MAX_KEYS];
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [31:0] t_rd_q, x_rd_q, y_rd_q, z_rd_q;
	logic wr_en;
	logic slot_ok;

	logic [6:0] key_count_q;
	state_t state_q;
	logic [31:0] query_q, t0_q, span_q;
	logic [NW-1:0] lo_q, hi_q, n_q;
	logic [AW-1:0] mid_q;
	logic [AB-1:0] alpha_q;
	logic [32:0] rem_q;
	logic [4:0] cnt_q;
	logic [1:0] comp_q;
	logic signed [31:0] v0_q [3];
	logic signed [31:0] res_q [3];
	logic signed [57:0] prod_s1;

	logic [NW-1:0] n_eff;
	logic [NW:0] mid_sum;
	logic [33:0] rem_sh;
	logic signed [32:0] diff;
	logic signed [31:0] v1_sel, v0_sel;
	logic signed [58:0] rounded;

	assign pready = 1'b1;
	assign prdata = {25'd0, key_count_q};
	assign in_ready = (state_q == S_IDLE);
	assign slot_ok = (32'(key_slot) < 32'(MAX_KEYS));
	assign wr_addr = AW'(key_slot);
	assign wr_en = in_valid && in_ready && (op == kvi_pkg::OP_LOAD) && slot_ok;

	always_comb begin
		if (key_count_q == 7'd0) begin
			n_eff = NW'(1);
		end else if (32'(key_count_q) > 32'(MAX_KEYS)) begin
			n_eff = NW'(MAX_KEYS);
		end else begin
			n_eff = NW'(key_count_q);
		end
		mid_sum = ({1'b0, lo_q} + {1'b0, hi_q} + (NW+1)'(1)) >> 1;
		rem_sh = {rem_q, 1'b0};
		unique case (comp_q)
			2'd0: begin v1_sel = x_rd_q; v0_sel = v0_q[0]; end
			2'd1: begin v1_sel = y_rd_q; v0_sel = v0_q[1]; end
			default: begin v1_sel = z_rd_q; v0_sel = v0_q[2]; end
		endcase
		diff = 33'(v1_sel) - 33'(v0_sel);
		rounded = (59'(prod_s1) + 59'(1 << (AB-1))) >>> AB;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[wr_addr] <= key_time;
			x_mem[wr_addr] <= value_x;
			y_mem[wr_addr] <= value_y;
			z_mem[wr_addr] <= value_z;
		end
		t_rd_q <= time_mem[rd_addr];
		x_rd_q <= x_mem[rd_addr];
		y_rd_q <= y_mem[rd_addr];
		z_rd_q <= z_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 7'd1;
		end else if (psel && penable && pwrite && paddr == kvi_pkg::REG_KEY_COUNT) begin
			key_count_q <= pwdata[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			rd_addr <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && op == kvi_pkg::OP_EVAL) begin
						query_q <= query_time;
						n_q <= n_eff;
						rd_addr <= '0;
						lo_q <= '0;
						hi_q <= n_eff - NW'(1);
						state_q <= S_FIRST;
					end
				end
				S_FIRST: begin
					// read of slot 0 lands next cycle
					state_q <= S_SRCH_A;
				end
				S_SRCH_A: begin
					// first visit only: the search has not narrowed yet and slot 0 is on the port
					if (lo_q == '0 && hi_q == n_q - NW'(1) && query_q < t_rd_q
							&& rd_addr == '0) begin
						left_slot <= '0;
						clamp_kind <= kvi_pkg::CLAMP_FIRST;
						state_q <= S_OUT;
						out_valid <= 1'b1;
						out_x <= x_rd_q;
						out_y <= y_rd_q;
						out_z <= z_rd_q;
					end else if (lo_q < hi_q) begin
						mid_q <= AW'(mid_sum);
						rd_addr <= AW'(mid_sum);
						cnt_q <= 5'd31;
						state_q <= S_SRCH_R;
					end else begin
						rd_addr <= AW'(lo_q);
						cnt_q <= 5'd30;
						state_q <= S_LEFT;
					end
				end
				S_SRCH_R: begin
					// let the registered mid read land before comparing
					if (cnt_q == 5'd31) begin
						cnt_q <= 5'd30;
					end else begin
						if (t_rd_q <= query_q) begin
							lo_q <= NW'(mid_q);
						end else begin
							hi_q <= NW'(mid_q) - NW'(1);
						end
						state_q <= S_SRCH_A;
					end
				end
				S_LEFT: begin
					if (cnt_q != 5'd29) begin
						cnt_q <= 5'd29;
					end else begin
						t0_q <= t_rd_q;
						v0_q[0] <= x_rd_q;
						v0_q[1] <= y_rd_q;
						v0_q[2] <= z_rd_q;
						left_slot <= 6'(lo_q);
						if (lo_q == n_q - NW'(1)) begin
							out_x <= x_rd_q;
							out_y <= y_rd_q;
							out_z <= z_rd_q;
							clamp_kind <= kvi_pkg::CLAMP_LAST;
							out_valid <= 1'b1;
							state_q <= S_OUT;
						end else begin
							rd_addr <= AW'(lo_q + NW'(1));
							cnt_q <= 5'd28;
							state_q <= S_RIGHT;
						end
					end
				end
				S_RIGHT: begin
					if (cnt_q == 5'd28) begin
						cnt_q <= 5'd27;
					end else begin
						clamp_kind <= kvi_pkg::CLAMP_NONE;
						span_q <= t_rd_q - t0_q;
						if (t_rd_q <= t0_q) begin
							out_x <= v0_q[0];
							out_y <= v0_q[1];
							out_z <= v0_q[2];
							out_valid <= 1'b1;
							state_q <= S_OUT;
						end else if (query_q - t0_q >= t_rd_q - t0_q) begin
							out_x <= x_rd_q;
							out_y <= y_rd_q;
							out_z <= z_rd_q;
							out_valid <= 1'b1;
							state_q <= S_OUT;
						end else begin
							// d < span, so the quotient has no integer bits and alpha is its 24 fraction bits
							rem_q <= {1'b0, query_q - t0_q};
							cnt_q <= 5'(AB - 1);
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					// restoring division, one quotient bit a cycle
					if (rem_sh >= {2'b0, span_q}) begin
						rem_q <= 33'(rem_sh - {2'b0, span_q});
						alpha_q <= {alpha_q[AB-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh[32:0];
						alpha_q <= {alpha_q[AB-2:0], 1'b0};
					end
					if (cnt_q == 5'd0) begin
						comp_q <= 2'd0;
						state_q <= S_MUL;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				S_MUL: begin
					// right vector is still on the read port
					prod_s1 <= diff * $signed({1'b0, alpha_q});
					state_q <= S_ADD;
				end
				S_ADD: begin
					res_q[comp_q] <= 32'(v0_sel + 32'(rounded));
					if (comp_q == 2'd2) begin
						out_x <= res_q[0];
						out_y <= res_q[1];
						out_z <= 32'(v0_sel + 32'(rounded));
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end else begin
						comp_q <= comp_q + 2'd1;
						state_q <= S_RDX;
					end
				end
				S_RDX: begin
					state_q <= S_MUL;
				end
				S_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("result dropped");
	ap_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> clamp_kind != 2'd3) else $error("bad clamp code");
endmodule
`default_nettype wire

[tb/keyframe_vector_interpolator_top_tb.sv]
// Testbench for keyframe_vector_interpolator_top: keyframe loads and evaluations
// with random idling, checked against a scoreboard that predicts each result.
// Depends on kvi_pkg and the block's RTL.
`timescale 1ns / 1ps
`default_nettype none
module keyframe_vector_interpolator_top_tb;

	typedef struct {
		logic        op;
		logic [5:0]  slot;
		logic [31:0] t, x, y, z, q;
	} key_item_t;

	typedef struct {
		logic [31:0] x, y, z;
		logic [5:0]  slot;
		kvi_pkg::clamp_t kind;
	} key_result_t;

	class interp_scoreboard;
		logic [31:0] times[64];
		logic [31:0] xs[64], ys[64], zs[64];
		logic [6:0]  key_count = 7'd1;
		key_result_t expected_q[$];
		int          mismatches = 0;

		function int keys_in_use();
			if (key_count == 0) return 1;
			if (key_count > 64) return 64;
			return key_count;
		endfunction

		function logic [31:0] mix(logic [31:0] a, logic [31:0] b, longint alpha);
			longint v0, diff, prod;
			v0 = $signed(a);
			diff = longint'($signed(b)) - v0;
			prod = diff * alpha + (longint'(1) << (kvi_pkg::AlphaBits - 1));
			return 32'(v0 + (prod >>> kvi_pkg::AlphaBits));
		endfunction

		function void push_key(int s, kvi_pkg::clamp_t kind, int rs);
			key_result_t r;
			r.x = xs[s]; r.y = ys[s]; r.z = zs[s];
			r.slot = 6'(rs);
			r.kind = kind;
			expected_q.push_back(r);
		endfunction

		function void note_input(key_item_t it);
			int n, lo, hi, mid;
			logic [31:0] d, span;
			longint alpha;
			key_result_t r;
			if (it.op == kvi_pkg::OP_LOAD) begin
				times[it.slot] = it.t;
				xs[it.slot] = it.x; ys[it.slot] = it.y; zs[it.slot] = it.z;
				return;
			end
			n = keys_in_use();
			if (it.q < times[0]) begin
				push_key(0, kvi_pkg::CLAMP_FIRST, 0);
				return;
			end
			lo = 0;
			hi = n - 1;
			while (lo < hi) begin
				mid = (lo + hi + 1) / 2;
				if (times[mid] <= it.q) lo = mid;
				else hi = mid - 1;
			end
			if (lo == n - 1) begin
				push_key(lo, kvi_pkg::CLAMP_LAST, lo);
				return;
			end
			if (times[lo + 1] <= times[lo]) begin
				push_key(lo, kvi_pkg::CLAMP_NONE, lo);
				return;
			end
			d = it.q - times[lo];
			span = times[lo + 1] - times[lo];
			if (d >= span) begin
				push_key(lo + 1, kvi_pkg::CLAMP_NONE, lo);
				return;
			end
			alpha = longint'({d, 24'b0} / {24'b0, span});
			r.x = mix(xs[lo], xs[lo + 1], alpha);
			r.y = mix(ys[lo], ys[lo + 1], alpha);
			r.z = mix(zs[lo], zs[lo + 1], alpha);
			r.slot = 6'(lo);
			r.kind = kvi_pkg::CLAMP_NONE;
			expected_q.push_back(r);
		endfunction

		function void check_result(key_result_t got);
			key_result_t e;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%h y=%h z=%h slot=%0d kind=%0d",
						got.x, got.y, got.z, got.slot, got.kind);
				return;
			end
			e = expected_q.pop_front();
			if (got.x !== e.x || got.y !== e.y || got.z !== e.z || got.slot !== e.slot ||
					got.kind !== e.kind) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: exp %h %h %h slot %0d kind %0d, got %h %h %h slot %0d kind %0d",
						e.x, e.y, e.z, e.slot, e.kind,
						got.x, got.y, got.z, got.slot, got.kind);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [0:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_ready;
	logic op = kvi_pkg::OP_LOAD;
	logic [5:0] key_slot = '0;
	logic [31:0] key_time = '0, query_time = '0;
	logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] out_x, out_y, out_z;
	logic [5:0] left_slot;
	logic [1:0] clamp_kind;

	logic quiet = 1'b0;
	logic hold_req = 1'b0;
	interp_scoreboard sb = new();

	keyframe_vector_interpolator_top DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("keyframe_vector_interpolator_top_tb NOT OK");
		$finish;
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		bit hold_done;
		key_result_t got;
		hold_left = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.x = out_x; got.y = out_y; got.z = out_z;
				got.slot = left_slot;
				got.kind = kvi_pkg::clamp_t'(clamp_kind);
				sb.check_result(got);
			end
			if (hold_req && !hold_done) begin
				hold_done = 1;
				hold_left = 600;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= quiet || ($urandom_range(99) >= 19);
			end
		end
	end

	task automatic send_item(key_item_t it);
		if (!quiet && $urandom_range(99) < 19) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		key_slot <= it.slot;
		key_time <= it.t;
		value_x <= it.x;
		value_y <= it.y;
		value_z <= it.z;
		query_time <= it.q;
		do @(posedge clk); while (!in_ready);
		sb.note_input(it);
	endtask

	// wait out outstanding results plus the block's evaluate latency
	task automatic drain();
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_key_count(logic [31:0] v);
		in_valid <= 1'b0;
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= kvi_pkg::REG_KEY_COUNT;
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.key_count = v[6:0];
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			default: return $urandom();
		endcase
	endfunction

	function automatic key_item_t load_item(int s, logic [31:0] t);
		key_item_t it;
		it.op = kvi_pkg::OP_LOAD;
		it.slot = 6'(s);
		it.t = t;
		it.x = rand_value();
		it.y = rand_value();
		it.z = rand_value();
		it.q = $urandom();
		return it;
	endfunction

	function automatic key_item_t eval_item(logic [31:0] q);
		key_item_t it;
		it = load_item($urandom_range(63), $urandom());
		it.op = kvi_pkg::OP_EVAL;
		it.q = q;
		return it;
	endfunction

	// load keeping times ordered most of the time; some duplicates and disorder
	function automatic key_item_t random_load();
		int s, pick;
		logic [31:0] lo, hi, t;
		s = $urandom_range(63);
		lo = (s > 0) ? sb.times[s - 1] : 32'h0;
		hi = (s < 63) ? sb.times[s + 1] : 32'hFFFF_FFFF;
		pick = $urandom_range(99);
		if (pick < 8) t = lo;
		else if (pick < 16) t = $urandom();
		else if (lo < hi) t = $urandom_range(hi - 1, lo + 1);
		else t = lo;
		return load_item(s, t);
	endfunction

	function automatic logic [31:0] random_query();
		int n, k, pick;
		logic [31:0] a, b;
		n = sb.keys_in_use();
		pick = $urandom_range(99);
		k = $urandom_range(n - 1);
		if (pick < 15) return $urandom();
		if (pick < 30) return sb.times[k];
		if (pick < 35) return sb.times[0] - 1;
		if (k == n - 1) return sb.times[k] + $urandom_range(3);
		a = sb.times[k];
		b = sb.times[k + 1];
		if (a < b) return $urandom_range(b, a);
		return $urandom();
	endfunction

	initial begin
		logic [31:0] t;
		int p, i;
		logic [31:0] counts[6];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single key at reset count: before, at, and after the key
		send_item(load_item(0, 32'h0001_0000));
		send_item(eval_item(32'h0));
		send_item(eval_item(32'h0001_0000));
		send_item(eval_item(32'hFFFF_FFFF));

		// full table, strictly increasing times
		write_key_count(64);
		t = $urandom_range(32'h0010_0000);
		for (i = 0; i < 64; i++) begin
			send_item(load_item(i, t));
			t = t + $urandom_range(32'h03F0_0000, 1);
		end
		send_item(eval_item(32'h0));
		send_item(eval_item(sb.times[0]));
		send_item(eval_item(sb.times[63]));
		send_item(eval_item(32'hFFFF_FFFF));
		send_item(eval_item(sb.times[31] + 1));
		// reload a key and query midway to the next, then make a zero-length and a reversed interval
		send_item(load_item(10, sb.times[10]));
		send_item(eval_item(sb.times[10] + (sb.times[11] - sb.times[10]) / 2));
		send_item(load_item(21, sb.times[20]));
		send_item(eval_item(sb.times[20]));
		send_item(load_item(41, sb.times[40] - 1));
		send_item(eval_item(sb.times[40] + 5));

		counts = '{64, 0, 127, 2, 33, 64};
		for (p = 0; p < 6; p++) begin
			write_key_count(p == 4 ? $urandom_range(64, 1) : counts[p]);
			quiet <= (p == 3);
			for (i = 0; i < 170; i++) begin
				if (p == 0 && i == 60) hold_req <= 1'b1;
				if ($urandom_range(99) < 25) send_item(random_load());
				else send_item(eval_item(random_query()));
			end
		end
		in_valid <= 1'b0;
		quiet <= 1'b0;
		drain();
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("keyframe_vector_interpolator_top_tb OK");
		else
			$display("keyframe_vector_interpolator_top_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
